/* hw/rtl/hrq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hrq_pkg;

    localparam logic [9:0]        HUM_MAX        = 10'd1000;
    localparam logic signed [11:0] HUM_MAX_S     = 12'sd1000;
    localparam logic [2:0]        BAD_PHASE_LAST = 3'd4;
    localparam logic signed [8:0] CAL_OFFSET_RST = 9'sd0;
    localparam logic [31:0]       THROTTLE_RST   = 32'd30000;

    typedef enum logic [0:0] {
        CFG_CAL_OFFSET = 1'b0,
        CFG_THROTTLE   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] raw_humidity;
        logic               read_failed;
        logic [31:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic [9:0] held_humidity;
        logic       humidity_valid;
        logic       has_value;
        logic       reinit_request;
        logic       error_event;
    } t_out_item;

    typedef struct packed {
        logic signed [8:0] calibration_offset;
        logic [31:0]       error_throttle_ms;
    } t_cfg;

endpackage

`default_nettype wire

/* hw/rtl/hrq_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrq_cfg_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire hrq_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    output hrq_pkg::t_cfg          o_cfg
);

    hrq_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.calibration_offset <= hrq_pkg::CAL_OFFSET_RST;
            r_cfg.error_throttle_ms  <= hrq_pkg::THROTTLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hrq_pkg::CFG_CAL_OFFSET: begin
                    r_cfg.calibration_offset <= $signed(i_cfg_data[8:0]);
                end
                hrq_pkg::CFG_THROTTLE: begin
                    r_cfg.error_throttle_ms <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hrq_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrq_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire hrq_pkg::t_in_item i_item,
    input  wire hrq_pkg::t_cfg     i_cfg,
    output hrq_pkg::t_out_item     o_result
);

    logic [9:0]  r_held_value;
    logic        r_ever_good;
    logic [2:0]  r_bad_phase;
    logic        r_bad_reached_five;
    logic [31:0] r_last_error_time;

    logic [9:0]  n_held_value;
    logic        n_ever_good;
    logic [2:0]  n_bad_phase;
    logic        n_bad_reached_five;
    logic [31:0] n_last_error_time;

    logic               good;
    logic signed [11:0] cal_sum;
    logic [31:0]        elapsed;
    logic               reinit;
    logic               event_hit;

    // raw fits in 12 bits whenever the reading is good
    assign good = !i_item.read_failed && !i_item.raw_humidity[15]
                  && ($unsigned(i_item.raw_humidity) <= 16'(hrq_pkg::HUM_MAX));
    assign cal_sum = $signed(i_item.raw_humidity[11:0])
                     + $signed({{3{i_cfg.calibration_offset[8]}}, i_cfg.calibration_offset});
    assign elapsed = i_item.now_ms - r_last_error_time;

    always_comb begin
        n_held_value       = r_held_value;
        n_ever_good        = r_ever_good;
        n_bad_phase        = r_bad_phase;
        n_bad_reached_five = r_bad_reached_five;
        n_last_error_time  = r_last_error_time;
        reinit             = 1'b0;
        event_hit          = 1'b0;
        if (good) begin
            if (cal_sum[11]) begin
                n_held_value = '0;
            end else if (cal_sum > hrq_pkg::HUM_MAX_S) begin
                n_held_value = hrq_pkg::HUM_MAX;
            end else begin
                n_held_value = cal_sum[9:0];
            end
            n_ever_good        = 1'b1;
            n_bad_phase        = '0;
            n_bad_reached_five = 1'b0;
        end else begin
            // wrap the run counter on the fifth bad reading in a row
            if (r_bad_phase >= hrq_pkg::BAD_PHASE_LAST) begin
                n_bad_phase        = '0;
                reinit             = 1'b1;
                n_bad_reached_five = 1'b1;
            end else begin
                n_bad_phase = r_bad_phase + 3'd1;
            end
            if (n_bad_reached_five && (elapsed > i_cfg.error_throttle_ms)) begin
                event_hit         = 1'b1;
                n_last_error_time = i_item.now_ms;
            end
        end
    end

    assign o_result.held_humidity  = n_held_value;
    assign o_result.humidity_valid = good;
    assign o_result.has_value      = n_ever_good;
    assign o_result.reinit_request = reinit;
    assign o_result.error_event    = event_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_value       <= '0;
            r_ever_good        <= 1'b0;
            r_bad_phase        <= '0;
            r_bad_reached_five <= 1'b0;
            r_last_error_time  <= '0;
        end else if (i_fire) begin
            r_held_value       <= n_held_value;
            r_ever_good        <= n_ever_good;
            r_bad_phase        <= n_bad_phase;
            r_bad_reached_five <= n_bad_reached_five;
            r_last_error_time  <= n_last_error_time;
        end
    end

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad_phase <= hrq_pkg::BAD_PHASE_LAST)
        else $error("bad run phase out of range");

    a_good_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && good |=> r_bad_phase == 3'd0 && !r_bad_reached_five && r_ever_good)
        else $error("good reading did not clear the bad run");

    a_reinit_sets_five: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && reinit |=> r_bad_reached_five && r_bad_phase == 3'd0)
        else $error("reinit did not mark the run as persistent");

    a_event_stamps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && event_hit |=> r_last_error_time == $past(i_item.now_ms))
        else $error("error event did not record its time");

endmodule

`default_nettype wire

/* hw/rtl/humidity_reading_qualifier.sv */
// Humidity reading qualifier.
// Input channel: i_in_valid / o_in_stall carry one transaction of type t_in_item
// (raw reading in tenths of a percent, read-failed flag, millisecond time).
// Output channel: o_out_valid / i_out_stall carry one t_out_item per input
// transaction: held value, this reading's validity, has-value flag, reinit
// request on every fifth bad reading in a row, and throttled error event.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is the calibration offset, index 1 the error throttle in ms. Write
// only while no transaction is in flight. o_cfg_ready is always high.
// The input register captures each accepted transaction, and the combinational
// qualifier logic then writes its result into the result register once that
// register is free or draining. One transaction is accepted per cycle while
// o_in_stall is low.
// Reset (synchronous, active low) clears both registers' valid flags and the
// held state; offset resets to 0 and throttle to 30000 ms.
// When i_out_stall holds a pending result, one more transaction is still
// taken into the input register; after that o_in_stall rises until the
// result drains.
`timescale 1ns / 1ps
`default_nettype none

module humidity_reading_qualifier (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire hrq_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output hrq_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire hrq_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);

    logic               r_in_valid;
    hrq_pkg::t_in_item  r_in;
    logic               r_out_valid;
    hrq_pkg::t_out_item r_out;

    hrq_pkg::t_cfg      cfg;
    hrq_pkg::t_out_item result;
    logic               advance;
    logic               in_accept;

    // move the held transaction on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    hrq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hrq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_humidity_reading_qualifier.sv */
`timescale 1ns / 1ps

module tb_humidity_reading_qualifier;

    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int ITEMS_PER_MODE = 420;
    localparam int CHUNK_ITEMS    = 60;
    localparam int HOLD_CYCLES    = 300;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    hrq_pkg::t_in_item   in_item   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    hrq_pkg::t_out_item  out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    hrq_pkg::t_cfg_idx   cfg_index = hrq_pkg::CFG_CAL_OFFSET;
    logic [31:0]         cfg_data  = '0;

    humidity_reading_qualifier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Qualifier state as the block should hold it
    logic signed [8:0] cal_offset    = hrq_pkg::CAL_OFFSET_RST;
    logic [31:0]       throttle_ms   = hrq_pkg::THROTTLE_RST;
    logic [9:0]        held_value    = '0;
    logic              ever_good     = 1'b0;
    logic [2:0]        bad_phase     = '0;
    logic              bad_run_long  = 1'b0;
    logic [31:0]       last_error_ms = '0;

    hrq_pkg::t_out_item expected_results[$];
    logic [31:0]        clock_ms = '0;

    int tx_idle_pct      = 0;
    int rx_idle_pct      = 0;
    int hold_token       = 0;
    int hold_seen        = 0;
    int hold_left        = 0;
    int quiet_cycles     = 0;
    int readings_sent    = 0;
    int results_checked  = 0;
    int mismatches       = 0;
    int reinit_count     = 0;
    int event_count      = 0;
    int settings_applied = 0;

    function automatic hrq_pkg::t_out_item qualify_reading(hrq_pkg::t_in_item rd);
        hrq_pkg::t_out_item res;
        logic               good;
        int                 calibrated;
        logic [31:0]        elapsed;
        res  = '0;
        good = !rd.read_failed && int'(rd.raw_humidity) >= 0
               && int'(rd.raw_humidity) <= int'(hrq_pkg::HUM_MAX);
        if (good) begin
            calibrated = int'(rd.raw_humidity) + int'(cal_offset);
            if (calibrated < 0) calibrated = 0;
            if (calibrated > int'(hrq_pkg::HUM_MAX)) calibrated = int'(hrq_pkg::HUM_MAX);
            held_value   = 10'(calibrated);
            ever_good    = 1'b1;
            bad_phase    = '0;
            bad_run_long = 1'b0;
        end else begin
            if (bad_phase >= hrq_pkg::BAD_PHASE_LAST) begin
                bad_phase          = '0;
                res.reinit_request = 1'b1;
                bad_run_long       = 1'b1;
            end else begin
                bad_phase = bad_phase + 3'd1;
            end
            // wrapping distance since the last error
            elapsed = rd.now_ms - last_error_ms;
            if (bad_run_long && elapsed > throttle_ms) begin
                res.error_event = 1'b1;
                last_error_ms   = rd.now_ms;
            end
        end
        res.held_humidity  = held_value;
        res.humidity_valid = good;
        res.has_value      = ever_good;
        return res;
    endfunction

    // Leaves valid high so that a following reading can go out back to back
    task automatic send_reading(input logic [15:0] raw, input logic failed,
                                input logic [31:0] now);
        hrq_pkg::t_in_item  rd;
        hrq_pkg::t_out_item res;
        rd.raw_humidity = raw;
        rd.read_failed  = failed;
        rd.now_ms       = now;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= rd;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        res = qualify_reading(rd);
        expected_results.push_back(res);
        readings_sent++;
        if (res.reinit_request) reinit_count++;
        if (res.error_event) event_count++;
    endtask

    // Drop valid and wait until every transaction has drained
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input hrq_pkg::t_cfg_idx idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            hrq_pkg::CFG_CAL_OFFSET: cal_offset = data[8:0];
            hrq_pkg::CFG_THROTTLE:   throttle_ms = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int offset, input logic [31:0] throttle);
        settle_block();
        write_register(hrq_pkg::CFG_CAL_OFFSET, 32'(offset));
        write_register(hrq_pkg::CFG_THROTTLE, throttle);
        settings_applied++;
    endtask

    // One burst: a run of good readings, a run of bad ones, or a single noise reading
    task automatic send_random_burst(input logic [31:0] step_max);
        int          kind;
        int          len;
        logic [15:0] raw;
        logic        failed;
        kind = $urandom_range(99);
        len  = (kind < 50) ? $urandom_range(6, 1) : (kind < 90) ? $urandom_range(12, 1) : 1;
        for (int k = 0; k < len; k++) begin
            clock_ms = clock_ms + $urandom_range(step_max, 0);
            if (kind < 50) begin
                raw    = 16'($urandom_range(1000, 0));
                failed = 1'b0;
            end else if (kind < 90) begin
                case ($urandom_range(2, 0))
                    0: begin
                        raw    = 16'($urandom);
                        failed = 1'b1;
                    end
                    1: begin
                        raw    = 16'($urandom_range(32767, 1001));
                        failed = 1'b0;
                    end
                    default: begin
                        raw    = 16'($urandom_range(65535, 32768));
                        failed = 1'b0;
                    end
                endcase
            end else begin
                raw      = 16'($urandom);
                failed   = 1'($urandom);
                clock_ms = $urandom;
            end
            send_reading(raw, failed, clock_ms);
        end
    endtask

    // Reset defaults: offset 0, throttle 30000
    task automatic test_field_extremes();
        send_reading(16'd0, 1'b1, 32'd0);
        send_reading(16'd0, 1'b0, 32'd1);
        send_reading(16'd1000, 1'b0, 32'd2);
        send_reading(16'd1001, 1'b0, 32'd3);
        send_reading(16'hFFFF, 1'b0, 32'd4);
        send_reading(16'h8000, 1'b0, 32'd5);
        send_reading(16'h7FFF, 1'b0, 32'hFFFF_FFFF);
        // failed flag with an in-range number
        send_reading(16'd500, 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_calibration_clamp();
        apply_setting(-200, hrq_pkg::THROTTLE_RST);
        send_reading(16'd100, 1'b0, 32'd10);
        send_reading(16'd1000, 1'b0, 32'd11);
        apply_setting(200, hrq_pkg::THROTTLE_RST);
        send_reading(16'd900, 1'b0, 32'd12);
        send_reading(16'd0, 1'b0, 32'd13);
    endtask

    task automatic test_bad_run_and_throttle();
        apply_setting(0, 32'd100);
        // short bad run: no reinit, no error
        for (int k = 0; k < 4; k++) send_reading(16'd2000, 1'b0, 32'hFFFF_FF00);
        send_reading(16'd400, 1'b0, 32'hFFFF_FF00);
        for (int k = 0; k < 5; k++) send_reading(16'd0, 1'b1, 32'hFFFF_FFF0 + 32'(k));
        // across the time wrap: exactly the throttle, then one past it
        send_reading(16'd0, 1'b1, 32'h0000_0058);
        send_reading(16'd0, 1'b1, 32'h0000_0059);
        apply_setting(0, 32'hFFFF_FFFF);
        for (int k = 0; k < 3; k++) send_reading(16'hC000, 1'b0, 32'h8000_0000);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int          target;
        int          chunk_end;
        int          offset;
        logic [31:0] throttle;
        logic [31:0] step_max;
        tx_idle_pct  = tx_pct;
        rx_idle_pct <= rx_pct;
        target = readings_sent + ITEMS_PER_MODE;
        while (readings_sent < target) begin
            case ($urandom_range(4, 0))
                0:       offset = -200;
                1:       offset = 200;
                2:       offset = 0;
                default: offset = int'($urandom_range(400, 0)) - 200;
            endcase
            case ($urandom_range(5, 0))
                0:       throttle = 32'd0;
                1:       throttle = 32'hFFFF_FFFF;
                2:       throttle = hrq_pkg::THROTTLE_RST;
                3:       throttle = $urandom_range(64, 1);
                4:       throttle = $urandom_range(5000, 100);
                default: throttle = $urandom;
            endcase
            apply_setting(offset, throttle);
            // pace time so elapsed gaps land on both sides of the throttle
            step_max  = (throttle > 32'h0100_0000) ? 32'h0100_0000 : throttle / 2 + 2;
            chunk_end = readings_sent + CHUNK_ITEMS;
            while (readings_sent < chunk_end) send_random_burst(step_max);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        hold_token  <= hold_token + 1;
        repeat (8) send_random_burst(32'd50);
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        hrq_pkg::t_out_item want;
        logic               bad;
        if (i_rst_n && out_valid && !out_stall) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: held %0d valid %b has %b reinit %b event %b",
                             out_item.held_humidity, out_item.humidity_valid,
                             out_item.has_value, out_item.reinit_request,
                             out_item.error_event);
            end else begin
                want = expected_results.pop_front();
                bad  = (out_item.held_humidity !== want.held_humidity)
                       || (out_item.humidity_valid !== want.humidity_valid)
                       || (out_item.has_value !== want.has_value)
                       || (out_item.reinit_request !== want.reinit_request)
                       || (out_item.error_event !== want.error_event);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected held %0d valid %b has %b reinit %b ",
                                  "event %b, got held %0d valid %b has %b reinit %b event %b"},
                                 results_checked, want.held_humidity, want.humidity_valid,
                                 want.has_value, want.reinit_request, want.error_event,
                                 out_item.held_humidity, out_item.humidity_valid,
                                 out_item.has_value, out_item.reinit_request,
                                 out_item.error_event);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("humidity_reading_qualifier: mismatch");
            $finish;
        end
    end

    initial begin
        tx_idle_pct  = 23;
        rx_idle_pct <= 52;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_calibration_clamp();
        test_bad_run_and_throttle();
        test_random_traffic(23, 52);
        test_random_traffic(52, 23);
        test_random_traffic(0, 0);
        test_backpressure();
        settle_block();

        $display("covered %0d readings and %0d results, %0d reinit requests, %0d error events",
                 readings_sent, results_checked, reinit_count, event_count);
        $display("across %0d register settings, stall patterns both ways and a long hold-off",
                 settings_applied);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("humidity_reading_qualifier: match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("humidity_reading_qualifier: mismatch");
        end
        $finish;
    end

endmodule
